/* src/prefix_code_bit_decoder_top_assert.svh */
// assertion macros for the prefix code bit decoder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef PREFIX_CODE_BIT_DECODER_TOP_ASSERT_SVH
`define PREFIX_CODE_BIT_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PCBD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PCBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pcbd_pkg.sv */
// shared constants, types and helpers of the prefix code bit decoder
// no dependencies; used by the interfaces, the cell, the top level and the checker
package pcbd_pkg;

  // table and code sizes
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;

  // fixed field widths
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int CLEN_W = 6;

  // each cell holds a group of table entries
  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int NUM_CELLS  = (SYMBOL_COUNT + LANES - 1) / LANES;
  localparam int CELL_IDX_W = SYM_W - LANE_W;

  // partial code register and compare widths
  localparam int PART_W    = MAX_CODE_LEN;
  localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
  localparam int CMP_W     = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int CMP_LEN_W = (LEN_W > CLEN_W) ? LEN_W : CLEN_W;

  // operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // control states of the top level
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  // query token that walks down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [SYM_W-1:0]     sym;
    logic [CMP_W-1:0]     bits;
    logic [CMP_LEN_W-1:0] len;
  } token_t;

  // table entry write, broadcast to all cells
  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] code;
  } load_t;

  // keep only the low len bits of a code
  function automatic logic [CODE_W-1:0] low_mask(input logic [CLEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    if (len >= CLEN_W'(CODE_W)) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return m;
  endfunction

endpackage

/* src/pcbd_if.sv */
// valid/ready channel interfaces for the input items and the result items
// depends on pcbd_pkg for the field widths
interface pcbd_in_if;
  import pcbd_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [SYM_W-1:0]  symbol;
  logic [CLEN_W-1:0] code_len;
  logic [CODE_W-1:0] code_bits;
  logic              bit_req;
  logic              final_req;

  modport source (output valid, op, symbol, code_len, code_bits, bit_req, final_req,
                  input ready);
  modport sink (input valid, op, symbol, code_len, code_bits, bit_req, final_req,
                output ready);
endinterface

interface pcbd_out_if;
  import pcbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] decoded_symbol;
  logic             overflow;

  modport source (output valid, decoded_symbol, overflow, input ready);
  modport sink (input valid, decoded_symbol, overflow, output ready);
endinterface

/* src/pcbd_cell.sv */
// one cell of the match chain: a group of table entries and a token stage
// depends on pcbd_pkg for the token and load types
module pcbd_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [pcbd_pkg::CELL_IDX_W-1:0] idx_i,
  input  logic                            we_i,
  input  pcbd_pkg::load_t                 load_i,
  input  pcbd_pkg::token_t                tok_i,
  output pcbd_pkg::token_t                tok_o
);
  import pcbd_pkg::*;

  logic [CLEN_W-1:0] len_q  [LANES];
  logic [CODE_W-1:0] code_q [LANES];
  logic [LANES-1:0]  hit;
  logic              hit_any;
  logic [LANE_W-1:0] hit_lane;
  token_t            tok_d, tok_q;

  // entry lengths, cleared at reset so no entry has a code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LANES; l++) len_q[l] <= '0;
    end else if (we_i) begin
      len_q[load_i.lane] <= load_i.len;
    end
  end

  // entry codes, masked to their length
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      code_q[load_i.lane] <= load_i.code & low_mask(load_i.len);
    end
  end

  // compare the query against every entry of this cell
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      hit[l] = (len_q[l] != '0) &&
               (CMP_LEN_W'(len_q[l]) == tok_i.len) &&
               (CMP_W'(code_q[l]) == tok_i.bits);
    end
  end

  // lowest matching lane wins
  always_comb begin
    hit_any  = 1'b0;
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hit[l]) begin
        hit_any  = 1'b1;
        hit_lane = LANE_W'(l);
      end
    end
  end

  // an earlier cell's match has priority over this one
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && hit_any) begin
      tok_d.found = 1'b1;
      tok_d.sym   = {idx_i, hit_lane};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* src/prefix_code_bit_decoder_top.sv */
// Prefix code bit decoder: table loads may follow back to back.
// A decoded bit walks the chain of NUM_CELLS cells (8 entries each), one cell a cycle;
// its result, if any, is registered once the token leaves the last cell, and input
// is not ready again until the search is done.
// A result in the output register does not block input; a second result that finds
// it still full is held and stalls input. Reset clears code lengths and partial code.
module prefix_code_bit_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcbd_in_if.sink           in_i,
  pcbd_out_if.source        out_o
);
  import pcbd_pkg::*;

  state_e               state_d, state_q;
  logic [PART_W-1:0]    part_bits_d, part_bits_q;
  logic [LEN_W-1:0]     part_len_d, part_len_q;
  logic                 fin_d, fin_q;
  logic                 launch_d, launch_q;
  logic                 accept, load_we, dec_acc;
  logic [NUM_CELLS-1:0] cell_we;
  load_t                load_w;
  token_t               tok_head;
  token_t               tok_w [NUM_CELLS+1];
  token_t               tok_last;
  logic                 res_has, res_ovf;
  logic [SYM_W-1:0]     res_sym;
  logic                 slot_free, out_load;
  logic [SYM_W-1:0]     out_sym_d, out_sym_q, pend_sym_q;
  logic                 out_ovf_d, out_ovf_q, pend_ovf_q;
  logic                 out_valid_q, pend_load;

  // input transfer decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_we    = accept && (in_i.op == OP_LOAD) &&
                      ({1'b0, in_i.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign dec_acc    = accept && (in_i.op == OP_DECODE);

  // table write, steered to the cell that holds the symbol
  assign load_w.lane = in_i.symbol[LANE_W-1:0];
  assign load_w.len  = in_i.code_len;
  assign load_w.code = in_i.code_bits;

  // query token enters the first cell
  always_comb begin
    tok_head       = '0;
    tok_head.valid = launch_q;
    tok_head.bits  = CMP_W'(part_bits_q);
    tok_head.len   = CMP_LEN_W'(part_len_q);
  end

  assign tok_w[0] = tok_head;

  // chain of match cells
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    assign cell_we[c] = load_we && (in_i.symbol[SYM_W-1:LANE_W] == CELL_IDX_W'(c));

    pcbd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (CELL_IDX_W'(c)),
      .we_i   (cell_we[c]),
      .load_i (load_w),
      .tok_i  (tok_w[c]),
      .tok_o  (tok_w[c+1])
    );
  end

  assign tok_last = tok_w[NUM_CELLS];

  // result of the token leaving the chain
  assign res_has   = tok_last.found || (part_len_q >= LEN_W'(MAX_CODE_LEN));
  assign res_ovf   = !tok_last.found;
  assign res_sym   = tok_last.found ? tok_last.sym : '0;
  assign slot_free = !out_valid_q || out_o.ready;

  // control sequence and partial code update
  always_comb begin
    state_d     = state_q;
    part_bits_d = part_bits_q;
    part_len_d  = part_len_q;
    fin_d       = fin_q;
    launch_d    = 1'b0;
    out_load    = 1'b0;
    pend_load   = 1'b0;
    out_sym_d   = res_sym;
    out_ovf_d   = res_ovf;
    unique case (state_q)
      ST_IDLE: begin
        if (dec_acc) begin
          part_bits_d = PART_W'({part_bits_q, in_i.bit_req});
          part_len_d  = part_len_q + LEN_W'(1);
          fin_d       = in_i.final_req;
          launch_d    = 1'b1;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_last.valid) begin
          if (res_has || fin_q) begin
            part_bits_d = '0;
            part_len_d  = '0;
          end
          if (res_has && !slot_free) begin
            pend_load = 1'b1;
            state_d   = ST_HOLD;
          end else begin
            out_load = res_has;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        out_sym_d = pend_sym_q;
        out_ovf_d = pend_ovf_q;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      part_bits_q <= '0;
      part_len_q  <= '0;
      fin_q       <= 1'b0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      part_bits_q <= part_bits_d;
      part_len_q  <= part_len_d;
      fin_q       <= fin_d;
      launch_q    <= launch_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q <= out_sym_d;
      out_ovf_q <= out_ovf_d;
    end
    if (pend_load) begin
      pend_sym_q <= res_sym;
      pend_ovf_q <= res_ovf;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.decoded_symbol = out_sym_q;
  assign out_o.overflow       = out_ovf_q;

endmodule

/* src/pcbd_checker.sv */
// port-level checks of the prefix code bit decoder, bound to its top level
// depends on pcbd_pkg and prefix_code_bit_decoder_top_assert.svh
`include "prefix_code_bit_decoder_top_assert.svh"

module pcbd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_op_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [pcbd_pkg::SYM_W-1:0] out_symbol_i,
  input logic                     out_overflow_i
);
  import pcbd_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // a stalled result holds its payload
  `PCBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_symbol_i) && $stable(out_overflow_i),
    "stalled result changed")

  // a table load never yields a result
  `PCBD_ASSERT_NEXT(a_load_silent, clk_i, rst_ni,
    in_xfer && (in_op_i == OP_LOAD) && !out_valid_i, !out_valid_i,
    "result after a table load")

  // a decoded bit occupies the chain, so no transfer in the next cycle
  `PCBD_ASSERT_NEXT(a_decode_busy, clk_i, rst_ni, in_xfer && (in_op_i == OP_DECODE),
    !in_ready_i, "input ready right after a decode transfer")

  // an overflow result carries no symbol
  `PCBD_ASSERT_IMPLY(a_ovf_sym, clk_i, rst_ni, out_valid_i && out_overflow_i,
    out_symbol_i == '0, "overflow result with nonzero symbol")

endmodule

bind prefix_code_bit_decoder_top pcbd_checker u_pcbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_op_i        (in_i.op),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_symbol_i   (out_o.decoded_symbol),
  .out_overflow_i (out_o.overflow)
);

/* tb/testbench.sv */
// self-checking testbench for prefix_code_bit_decoder_top: loads code tables, streams bits
// and checks every decoded symbol and overflow against a built-in table-match predictor
// depends on pcbd_pkg, pcbd_if and the decoder rtl
module testbench;
  import pcbd_pkg::*;

  typedef struct {
    logic              op;
    logic [SYM_W-1:0]  symbol;
    logic [CLEN_W-1:0] code_len;
    logic [CODE_W-1:0] code_bits;
    logic              bit_req;
    logic              final_req;
  } code_item_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             overflow;
  } decoded_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_LONG_STALLS
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcbd_in_if  in_if ();
  pcbd_out_if out_if ();

  prefix_code_bit_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  always #2 clk_i = ~clk_i;

  code_item_t pending_items [$];
  decoded_t   expected_decodes [$];
  int         fail_count = 0;

  // predictor copy of the code table and the partial code
  logic [CLEN_W-1:0] table_len  [SYMBOL_COUNT];
  logic [CODE_W-1:0] table_code [SYMBOL_COUNT];
  logic [CODE_W-1:0] partial_code;
  int                partial_len;

  // stimulus bookkeeping
  bit sym_taken [SYMBOL_COUNT];
  int live_symbols [$];

  // apply one accepted transfer to the predictor, queue its result if any
  function automatic void decode_transfer(input code_item_t it);
    decoded_t res;
    bit       hit;
    int       s;
    hit = 1'b0;
    if (it.op == OP_LOAD) begin
      table_len[it.symbol] = it.code_len;
      if (it.code_len >= CLEN_W'(CODE_W)) begin
        table_code[it.symbol] = it.code_bits;
      end else begin
        table_code[it.symbol] = it.code_bits & ((CODE_W'(1) << it.code_len) - CODE_W'(1));
      end
      return;
    end
    partial_code = {partial_code[CODE_W-2:0], it.bit_req};
    partial_len++;
    // lowest matching symbol wins
    for (s = 0; s < SYMBOL_COUNT; s++) begin
      if (!hit && table_len[s] != '0 && int'(table_len[s]) == partial_len &&
          table_code[s] == partial_code) begin
        hit          = 1'b1;
        res.symbol   = SYM_W'(s);
        res.overflow = 1'b0;
      end
    end
    if (!hit && partial_len >= MAX_CODE_LEN) begin
      hit          = 1'b1;
      res.symbol   = '0;
      res.overflow = 1'b1;
    end
    if (hit || it.final_req) begin
      partial_code = '0;
      partial_len  = 0;
    end
    if (hit) expected_decodes.push_back(res);
  endfunction

  // table load; bits above the code length get random filler
  function automatic void add_load(input int sym, input int len, input logic [CODE_W-1:0] code,
                                   input logic fin);
    code_item_t it;
    it.op        = OP_LOAD;
    it.symbol    = SYM_W'(sym);
    it.code_len  = CLEN_W'(len);
    it.code_bits = (len < CODE_W) ? (code | (CODE_W'($urandom()) << len)) : code;
    it.bit_req   = 1'($urandom_range(0, 1));
    it.final_req = fin;
    pending_items.push_back(it);
  endfunction

  // one compressed bit; load fields carry junk
  function automatic void add_bit(input logic b, input logic fin);
    code_item_t it;
    it.op        = OP_DECODE;
    it.symbol    = SYM_W'($urandom_range(0, 255));
    it.code_len  = CLEN_W'($urandom_range(0, 63));
    it.code_bits = $urandom();
    it.bit_req   = b;
    it.final_req = fin;
    pending_items.push_back(it);
  endfunction

  // all bits of a code, first bit most significant
  function automatic void add_code(input logic [CODE_W-1:0] code, input int len, input logic fin);
    int i;
    for (i = len - 1; i >= 0; i--) add_bit(code[i], fin && i == 0);
  endfunction

  function automatic int pick_free_symbol();
    int s;
    case ($urandom_range(0, 9))
      0:       s = 0;
      1:       s = SYMBOL_COUNT - 1;
      default: s = $urandom_range(0, SYMBOL_COUNT - 1);
    endcase
    while (sym_taken[s]) s = $urandom_range(0, SYMBOL_COUNT - 1);
    sym_taken[s] = 1'b1;
    return s;
  endfunction

  // one round: build a prefix-free code set, load it, then stream encoded symbols
  function automatic void add_round();
    logic [CODE_W-1:0] leaf_code [$];
    int                leaf_len [$];
    int                leaf_sym [$];
    bit                deep;
    int                k, idx, skip, n, i, j, s;
    deep = ($urandom_range(0, 5) == 0);
    k    = deep ? MAX_CODE_LEN + 1 : $urandom_range(2, 16);
    leaf_code.push_back('0);
    leaf_len.push_back(0);
    // split leaves; a deep round keeps splitting the newest leaf down to full length
    while (leaf_code.size() < k) begin
      idx = deep ? leaf_code.size() - 1 : $urandom_range(0, leaf_code.size() - 1);
      if (leaf_len[idx] < MAX_CODE_LEN) begin
        leaf_code.push_back({leaf_code[idx][CODE_W-2:0], 1'b1});
        leaf_len.push_back(leaf_len[idx] + 1);
        leaf_code[idx] = {leaf_code[idx][CODE_W-2:0], 1'b0};
        leaf_len[idx]++;
      end
    end

    // clear the previous table most of the time
    if ($urandom_range(0, 3) != 0) begin
      foreach (live_symbols[i]) begin
        add_load(live_symbols[i], 0, $urandom(), 1'($urandom_range(0, 1)));
      end
      live_symbols.delete();
    end
    foreach (sym_taken[i]) sym_taken[i] = 1'b0;

    // load codes, sometimes leaving one out so its path overflows
    skip = ($urandom_range(0, 2) == 0) ? $urandom_range(0, k - 1) : -1;
    for (i = 0; i < k; i++) begin
      s = pick_free_symbol();
      leaf_sym.push_back(s);
      if (i != skip) begin
        add_load(s, leaf_len[i], leaf_code[i], 1'($urandom_range(0, 1)));
        live_symbols.push_back(s);
      end
    end
    // duplicate code on another symbol
    if ($urandom_range(0, 3) == 0) begin
      i = $urandom_range(0, k - 1);
      s = pick_free_symbol();
      add_load(s, leaf_len[i], leaf_code[i], 1'($urandom_range(0, 1)));
      live_symbols.push_back(s);
    end
    // entry longer than the partial register can hold
    if ($urandom_range(0, 3) == 0) begin
      s = pick_free_symbol();
      add_load(s, $urandom_range(MAX_CODE_LEN + 1, 63), $urandom(), 1'($urandom_range(0, 1)));
      live_symbols.push_back(s);
    end

    // encoded stream with a little noise, reloads and final bits
    n = deep ? $urandom_range(6, 12) : $urandom_range(20, 60);
    for (j = 0; j < n; j++) begin
      case ($urandom_range(0, 19))
        0: begin
          repeat ($urandom_range(1, 3)) begin
            add_bit(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
          end
        end
        1: begin
          i = $urandom_range(0, k - 1);
          if (i != skip) begin
            add_load(leaf_sym[i], leaf_len[i], leaf_code[i], 1'($urandom_range(0, 1)));
          end
        end
        default: ;
      endcase
      i = $urandom_range(0, k - 1);
      add_code(leaf_code[i], leaf_len[i], $urandom_range(0, 24) == 0);
    end
  endfunction

  // driver: bursts of transfers with random gaps
  code_item_t driven_item;
  int         burst_left;
  int         gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.op        <= OP_LOAD;
      in_if.symbol    <= '0;
      in_if.code_len  <= '0;
      in_if.code_bits <= '0;
      in_if.bit_req   <= 1'b0;
      in_if.final_req <= 1'b0;
      burst_left = $urandom_range(1, 30);
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) decode_transfer(driven_item);
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          driven_item = pending_items.pop_front();
          in_if.valid     <= 1'b1;
          in_if.op        <= driven_item.op;
          in_if.symbol    <= driven_item.symbol;
          in_if.code_len  <= driven_item.code_len;
          in_if.code_bits <= driven_item.code_bits;
          in_if.bit_req   <= driven_item.bit_req;
          in_if.final_req <= driven_item.final_req;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45)
                                                     : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  rx_mode_e rx_mode;
  int       rx_mode_left;
  int       stall_run;
  decoded_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode      = RX_STEADY;
      rx_mode_left = 0;
      stall_run    = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_decodes.size() == 0) begin
          $error("unexpected result: decoded_symbol %0d overflow %0d",
                 out_if.decoded_symbol, out_if.overflow);
          fail_count++;
        end else begin
          want = expected_decodes.pop_front();
          if (out_if.decoded_symbol !== want.symbol) begin
            $error("decoded_symbol: expected %0d, actual %0d", want.symbol, out_if.decoded_symbol);
            fail_count++;
          end
          if (out_if.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, out_if.overflow);
            fail_count++;
          end
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(50, 400);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_if.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_run = $urandom_range(5, 30);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // stimulus, reset and end of run
  initial begin
    foreach (table_len[i]) begin
      table_len[i]  = '0;
      table_code[i] = '0;
    end
    partial_code = '0;
    partial_len  = 0;
    rst_ni <= 1'b0;

    // empty table, then final drops the partial code
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b1);
    // extremes, ambiguity, length zero and an over-long entry; final on load is ignored
    add_load(0, 0, '1, 1'b1);
    add_load(5, 2, 32'h2, 1'b0);
    add_load(3, 2, 32'h2, 1'b1);
    add_load(255, 1, '0, 1'b0);
    add_load(7, 40, 32'h1, 1'b0);
    add_load(128, 32, '1, 1'b0);
    add_code(32'h2, 2, 1'b0);
    add_bit(1'b0, 1'b0);
    // no match, then final clears the partial code
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b1);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b1);
    add_bit(1'b0, 1'b0);
    // match on the final bit
    add_code(32'h2, 2, 1'b1);
    // removing the lower duplicate lets the higher symbol match
    add_load(3, 0, '0, 1'b0);
    add_code(32'h2, 2, 1'b0);

    while (pending_items.size() < 1550) add_round();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (NUM_CELLS + 30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/pcbd_pkg.sv
src/pcbd_if.sv
src/pcbd_cell.sv
src/prefix_code_bit_decoder_top.sv
src/pcbd_checker.sv
tb/testbench.sv
